// ===== src/lkls_pkg.sv =====
// ----------------------------------------------------------------------------
// lkls_pkg: shared types and constants for the L1 k-nearest-neighbor scan
// Opcodes, queue command kinds, register indexes and fixed field widths.
// ----------------------------------------------------------------------------
package lkls_pkg;

    localparam int DEF_MAX_NEIGHBORS = 16;
    localparam int DEF_MAX_DIMENSION = 256;
    localparam int DEF_MAX_POINTS    = 65536;
    localparam int DEF_SAMPLE_BITS   = 16;

    // Width of an L1 distance; the accumulator saturates at its all-ones value.
    localparam int DIST_BITS    = 24;
    localparam int OPCODE_BITS  = 2;
    localparam int K_CFG_BITS   = 5;
    localparam int DIM_CFG_BITS = 9;

    localparam int APB_ADDR_BITS = 4;
    localparam int APB_DATA_BITS = 32;
    localparam int REG_SEL_BITS  = 2;

    // Depth of the command queue between the front and the back.
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [OPCODE_BITS-1:0] {
        OP_QUERY  = 2'd0,
        OP_POINT  = 2'd1,
        OP_FINISH = 2'd2,
        OP_NONE   = 2'd3
    } opcode_t;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_INSERT = 2'd1,
        CMD_FINISH = 2'd2
    } cmd_kind_t;

    typedef enum logic [REG_SEL_BITS-1:0] {
        REG_NEIGHBOR_COUNT = 2'd0,
        REG_DIMENSION      = 2'd1,
        REG_KEEP_RESULTS   = 2'd2
    } reg_index_t;

    typedef enum logic [1:0] {
        BACK_IDLE = 2'b01,
        BACK_EMIT = 2'b10
    } back_state_t;

    // Width helper that never returns less than one bit.
    function automatic int at_least_one(input int v);
        return (v < 1) ? 1 : v;
    endfunction

endpackage

// ===== src/lkls_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// lkls_cmd_fifo: short command queue between front and back
// Register-based first-in first-out buffer; push only when not full.
// ----------------------------------------------------------------------------
module lkls_cmd_fifo
    import lkls_pkg::*;
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = QUEUE_DEPTH
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             push,
    input  logic [WIDTH-1:0] push_data,
    input  logic             pop,
    output logic [WIDTH-1:0] head_data,
    output logic             full,
    output logic             empty
);

    localparam int PTR_W = at_least_one($clog2(DEPTH));
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(DEPTH));
    assign empty     = (count_reg == '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && !empty;
    assign head_data = entry_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== src/lkls_front.sv =====
// ----------------------------------------------------------------------------
// lkls_front: input word intake, query store and distance accumulation
// Classifies each word, keeps the query vector in a memory, sums absolute
// differences per point and queues clear, insert and finish commands.
// ----------------------------------------------------------------------------
module lkls_front
    import lkls_pkg::*;
#(
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION,
    parameter int MAX_POINTS    = DEF_MAX_POINTS,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    parameter int DIM_W         = $clog2(DEF_MAX_DIMENSION + 1),
    parameter int IDX_W         = $clog2(DEF_MAX_POINTS)
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  opcode_t                       in_op,
    input  logic signed [SAMPLE_BITS-1:0] in_sample,
    input  logic [DIM_W-1:0]              dim_eff,
    input  logic                          keep,
    input  logic                          q_full,
    output logic                          q_push,
    output cmd_kind_t                     q_kind,
    output logic [IDX_W-1:0]              q_index,
    output logic [DIST_BITS-1:0]          q_dist
);

    localparam int POS_W = at_least_one($clog2(MAX_DIMENSION));
    localparam int CNT_W = $clog2(MAX_POINTS + 1);
    localparam int SUM_W = ((SAMPLE_BITS > DIST_BITS) ? SAMPLE_BITS : DIST_BITS) + 1;
    localparam logic [DIST_BITS-1:0] ACC_MAX = {DIST_BITS{1'b1}};

    // Query vector memory; entries never written read as anything.
    logic signed [SAMPLE_BITS-1:0] query_mem [MAX_DIMENSION];
    logic signed [SAMPLE_BITS-1:0] qdata_reg;

    logic             loading_reg;
    logic [POS_W-1:0] pos_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             fresh_reg;
    logic [DIST_BITS-1:0] acc_reg;

    logic                          s2_valid_reg;
    cmd_kind_t                     s2_kind_reg;
    logic                          s2_fresh_reg;
    logic                          s2_ins_reg;
    logic [IDX_W-1:0]              s2_idx_reg;
    logic signed [SAMPLE_BITS-1:0] s2_sample_reg;

    logic             accept;
    logic             restart;
    logic [POS_W-1:0] pos_start, pos_cur, pos_after;
    logic [DIM_W-1:0] pos_inc;
    logic             wrap;
    logic             room;

    logic signed [SAMPLE_BITS:0] diff;
    logic [SAMPLE_BITS:0]        abs_diff;
    logic [SUM_W-1:0]            sum;
    logic [DIST_BITS-1:0]        acc_new;
    logic                        s2_needs_push, s2_retire;

    assign accept = in_valid && in_ready;

    // A query word after any other word, or a point word right after a query
    // load, starts again from the first sample position.
    assign restart   = (in_op == OP_QUERY && !loading_reg) || (in_op == OP_POINT && loading_reg);
    assign pos_start = restart ? '0 : pos_reg;
    assign pos_cur   = (DIM_W'(pos_start) >= dim_eff) ? '0 : pos_start;
    assign pos_inc   = DIM_W'(pos_cur) + DIM_W'(1);
    assign wrap      = (pos_inc >= dim_eff);
    assign pos_after = wrap ? '0 : POS_W'(pos_inc);
    assign room      = (cnt_reg < CNT_W'(MAX_POINTS));

    always_ff @(posedge aclk) begin
        if (accept && in_op == OP_QUERY) begin
            query_mem[pos_cur] <= in_sample;
        end
        if (accept && in_op == OP_POINT) begin
            qdata_reg <= query_mem[pos_cur];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            loading_reg <= 1'b0;
            pos_reg     <= '0;
            cnt_reg     <= '0;
            fresh_reg   <= 1'b1;
        end else if (accept) begin
            case (in_op)
                OP_QUERY: begin
                    loading_reg <= 1'b1;
                    pos_reg     <= pos_after;
                    if (!loading_reg) begin
                        cnt_reg   <= '0;
                        fresh_reg <= 1'b1;
                    end
                end
                OP_POINT: begin
                    loading_reg <= 1'b0;
                    pos_reg     <= pos_after;
                    fresh_reg   <= wrap;
                    if (wrap && room) begin
                        cnt_reg <= cnt_reg + CNT_W'(1);
                    end
                end
                OP_FINISH: begin
                    loading_reg <= 1'b0;
                    pos_reg     <= '0;
                    cnt_reg     <= '0;
                    fresh_reg   <= 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // Second stage: registered query sample meets the point sample.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s2_valid_reg <= 1'b0;
        end else if (accept) begin
            case (in_op)
                OP_QUERY:  s2_valid_reg <= !loading_reg && !keep;
                OP_POINT:  s2_valid_reg <= 1'b1;
                OP_FINISH: s2_valid_reg <= 1'b1;
                default:   s2_valid_reg <= 1'b0;
            endcase
        end else if (s2_retire) begin
            s2_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            case (in_op)
                OP_POINT:  s2_kind_reg <= CMD_INSERT;
                OP_FINISH: s2_kind_reg <= CMD_FINISH;
                default:   s2_kind_reg <= CMD_CLEAR;
            endcase
            s2_fresh_reg  <= fresh_reg || loading_reg;
            s2_ins_reg    <= wrap && room;
            s2_idx_reg    <= IDX_W'(cnt_reg);
            s2_sample_reg <= in_sample;
        end
    end

    always_comb begin
        diff     = {s2_sample_reg[SAMPLE_BITS-1], s2_sample_reg}
                 - {qdata_reg[SAMPLE_BITS-1], qdata_reg};
        abs_diff = diff[SAMPLE_BITS] ? (SAMPLE_BITS + 1)'(-diff) : (SAMPLE_BITS + 1)'(diff);
        sum      = SUM_W'(s2_fresh_reg ? '0 : acc_reg) + SUM_W'(abs_diff[SAMPLE_BITS-1:0]);
        acc_new  = (sum > SUM_W'(ACC_MAX)) ? ACC_MAX : DIST_BITS'(sum);
    end

    assign s2_needs_push = (s2_kind_reg != CMD_INSERT) || s2_ins_reg;
    assign s2_retire     = s2_valid_reg && (!s2_needs_push || !q_full);
    assign in_ready      = !s2_valid_reg || s2_retire;

    assign q_push  = s2_valid_reg && s2_needs_push && !q_full;
    assign q_kind  = s2_kind_reg;
    assign q_index = s2_idx_reg;
    assign q_dist  = acc_new;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg <= '0;
        end else if (s2_retire && s2_kind_reg == CMD_INSERT) begin
            acc_reg <= acc_new;
        end
    end

endmodule

// ===== src/lkls_back.sv =====
// ----------------------------------------------------------------------------
// lkls_back: sorted neighbor list and result emission
// Executes queued commands: sorted insertion, list clear, and
// emission of the list in ascending distance through an output register.
// ----------------------------------------------------------------------------
module lkls_back
    import lkls_pkg::*;
#(
    parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
    parameter int KW            = $clog2(DEF_MAX_NEIGHBORS + 1),
    parameter int IDX_W         = $clog2(DEF_MAX_POINTS)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic [KW-1:0]        k_eff,
    input  logic                 q_empty,
    input  cmd_kind_t            q_kind,
    input  logic [IDX_W-1:0]     q_index,
    input  logic [DIST_BITS-1:0] q_dist,
    output logic                 q_pop,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic [IDX_W-1:0]     out_index,
    output logic [DIST_BITS-1:0] out_dist,
    output logic                 out_vres,
    output logic                 out_last
);

    localparam int IW = at_least_one($clog2(MAX_NEIGHBORS));

    logic [DIST_BITS-1:0] dist_reg [MAX_NEIGHBORS];
    logic [IDX_W-1:0]     idx_reg  [MAX_NEIGHBORS];
    logic [KW-1:0]        occ_reg;
    logic [IW-1:0]        rd_reg;
    back_state_t          state_reg;

    logic                 out_valid_reg;
    logic [IDX_W-1:0]     out_index_reg;
    logic [DIST_BITS-1:0] out_dist_reg;
    logic                 out_vres_reg, out_last_reg;

    logic [MAX_NEIGHBORS-1:0] le;
    logic [IW-1:0]            km1;
    logic                     full, drop, do_insert;
    logic                     slot_free, rd_last;

    // Entry i ranks ahead of the new point (ties keep the older entry first).
    always_comb begin
        for (int i = 0; i < MAX_NEIGHBORS; i++) begin
            le[i] = (KW'(i) < occ_reg) && (dist_reg[i] <= q_dist);
        end
    end

    assign km1       = IW'(k_eff - KW'(1));
    assign full      = (occ_reg >= k_eff);
    assign drop      = full && le[km1];
    assign q_pop     = (state_reg == BACK_IDLE) && !q_empty;
    assign do_insert = q_pop && (q_kind == CMD_INSERT) && !drop;

    assign slot_free = !out_valid_reg || out_ready;
    assign rd_last   = (KW'(rd_reg) + KW'(1) == occ_reg);

    always_ff @(posedge aclk) begin
        if (do_insert) begin
            for (int i = 0; i < MAX_NEIGHBORS; i++) begin
                if (!le[i]) begin
                    if (i == 0 || le[(i == 0) ? 0 : i - 1]) begin
                        dist_reg[i] <= q_dist;
                        idx_reg[i]  <= q_index;
                    end else begin
                        dist_reg[i] <= dist_reg[(i == 0) ? 0 : i - 1];
                        idx_reg[i]  <= idx_reg[(i == 0) ? 0 : i - 1];
                    end
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            occ_reg   <= '0;
            rd_reg    <= '0;
            state_reg <= BACK_IDLE;
        end else begin
            case (state_reg)
                BACK_IDLE: begin
                    if (q_pop) begin
                        case (q_kind)
                            CMD_INSERT: begin
                                if (!drop && !full) begin
                                    occ_reg <= occ_reg + KW'(1);
                                end
                            end
                            CMD_CLEAR: occ_reg <= '0;
                            CMD_FINISH: begin
                                rd_reg    <= '0;
                                state_reg <= BACK_EMIT;
                            end
                            default: begin
                            end
                        endcase
                    end else if (occ_reg > k_eff) begin
                        // A lowered neighbor count drops the worst entries.
                        occ_reg <= k_eff;
                    end
                end
                BACK_EMIT: begin
                    if (slot_free) begin
                        if (occ_reg == '0 || rd_last) begin
                            state_reg <= BACK_IDLE;
                        end else begin
                            rd_reg <= rd_reg + IW'(1);
                        end
                    end
                end
                default: state_reg <= BACK_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == BACK_EMIT && slot_free) begin
            out_valid_reg <= 1'b1;
        end else if (out_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == BACK_EMIT && slot_free) begin
            if (occ_reg == '0) begin
                out_index_reg <= '0;
                out_dist_reg  <= '0;
                out_vres_reg  <= 1'b0;
                out_last_reg  <= 1'b1;
            end else begin
                out_index_reg <= idx_reg[rd_reg];
                out_dist_reg  <= dist_reg[rd_reg];
                out_vres_reg  <= 1'b1;
                out_last_reg  <= rd_last;
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_dist  = out_dist_reg;
    assign out_vres  = out_vres_reg;
    assign out_last  = out_last_reg;

endmodule

// ===== src/l1_knn_linear_scan.sv =====
// ----------------------------------------------------------------------------
// l1_knn_linear_scan: brute-force k-nearest-neighbor search by L1 distance
//
// Channel   Direction  Handshake          Word contents
// s_*       in         s_tvalid/s_tready  tdata: sample; tuser: opcode
// m_*       out        m_tvalid/m_tready  tdata: point_index, distance;
//                                         tuser: valid_res; tlast: last
// APB       in/out     psel/penable       neighbor_count, dimension,
//                                         keep_results at 0x0, 0x4, 0x8
//
// Input words are taken at one per cycle; the front part holds a single second
// stage where the registered query sample meets the point sample. Each
// finished point, up to MAX_POINTS per query, becomes one insert command that
// the back part carries out. A finish word makes the back emit the list at one
// word per cycle while m_tready is high (occupancy words, or one if empty);
// meanwhile the four-entry command queue absorbs input until it fills, then
// s_tready drops. Reset is synchronous and active low; it clears all control
// state but not the query memory, whose entries are undefined until written.
// ----------------------------------------------------------------------------
module l1_knn_linear_scan
    import lkls_pkg::*;
#(
    parameter int MAX_NEIGHBORS = DEF_MAX_NEIGHBORS,
    parameter int MAX_DIMENSION = DEF_MAX_DIMENSION,
    parameter int MAX_POINTS    = DEF_MAX_POINTS,
    parameter int SAMPLE_BITS   = DEF_SAMPLE_BITS,
    localparam int IDX_W        = at_least_one($clog2(MAX_POINTS)),
    localparam int SDATA_W      = ((SAMPLE_BITS + 7) / 8) * 8,
    localparam int MDATA_W      = ((IDX_W + DIST_BITS + 7) / 8) * 8
) (
    input  logic                     aclk,
    input  logic                     aresetn,

    // Input stream.
    input  logic                     s_tvalid,
    output logic                     s_tready,
    input  logic [SDATA_W-1:0]       s_tdata,   // [SAMPLE_BITS-1:0] sample
    input  logic [OPCODE_BITS-1:0]   s_tuser,   // [1:0] opcode

    // Result stream.
    output logic                     m_tvalid,
    input  logic                     m_tready,
    output logic [MDATA_W-1:0]       m_tdata,   // [IDX_W-1:0] point_index, then distance
    output logic [0:0]               m_tuser,   // [0] valid_res
    output logic                     m_tlast,

    // Configuration port.
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    output logic [APB_DATA_BITS-1:0] prdata,
    output logic                     pready
);

    localparam int KW    = $clog2(MAX_NEIGHBORS + 1);
    localparam int DIM_W = $clog2(MAX_DIMENSION + 1);
    localparam int CMD_W = 2 + IDX_W + DIST_BITS;

    // Configuration registers, kept as written; clamping happens below.
    logic [K_CFG_BITS-1:0]   k_cfg_reg;
    logic [DIM_CFG_BITS-1:0] dim_cfg_reg;
    logic                    keep_reg;

    logic             cfg_write;
    reg_index_t       reg_sel;
    logic [KW-1:0]    k_eff;
    logic [DIM_W-1:0] dim_eff;

    // Command queue between the front and the back.
    logic                 q_push, q_pop, q_full, q_empty;
    cmd_kind_t            push_kind;
    logic [IDX_W-1:0]     push_index;
    logic [DIST_BITS-1:0] push_dist;
    logic [CMD_W-1:0]     head_data;
    cmd_kind_t            head_kind;
    logic [IDX_W-1:0]     head_index;
    logic [DIST_BITS-1:0] head_dist;

    logic [IDX_W-1:0]     res_index;
    logic [DIST_BITS-1:0] res_dist;
    logic                 res_vres;

    // --------------------------------------------------------------------
    // APB register file. Writes land on the access cycle; reads are plain
    // combinational views of the stored values.
    // --------------------------------------------------------------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_sel   = reg_index_t'(paddr[REG_SEL_BITS+1:2]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_cfg_reg   <= K_CFG_BITS'(1);
            dim_cfg_reg <= DIM_CFG_BITS'(1);
            keep_reg    <= 1'b0;
        end else if (cfg_write) begin
            case (reg_sel)
                REG_NEIGHBOR_COUNT: k_cfg_reg   <= pwdata[K_CFG_BITS-1:0];
                REG_DIMENSION:      dim_cfg_reg <= pwdata[DIM_CFG_BITS-1:0];
                REG_KEEP_RESULTS:   keep_reg    <= pwdata[0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_sel)
            REG_NEIGHBOR_COUNT: prdata = APB_DATA_BITS'(k_cfg_reg);
            REG_DIMENSION:      prdata = APB_DATA_BITS'(dim_cfg_reg);
            REG_KEEP_RESULTS:   prdata = APB_DATA_BITS'(keep_reg);
            default:            prdata = '0;
        endcase
    end

    // Out-of-range settings are clamped into the range the storage supports.
    always_comb begin
        if (k_cfg_reg == '0) begin
            k_eff = KW'(1);
        end else if (int'(k_cfg_reg) > MAX_NEIGHBORS) begin
            k_eff = KW'(MAX_NEIGHBORS);
        end else begin
            k_eff = KW'(k_cfg_reg);
        end

        if (dim_cfg_reg == '0) begin
            dim_eff = DIM_W'(1);
        end else if (int'(dim_cfg_reg) > MAX_DIMENSION) begin
            dim_eff = DIM_W'(MAX_DIMENSION);
        end else begin
            dim_eff = DIM_W'(dim_cfg_reg);
        end
    end

    // --------------------------------------------------------------------
    // Front: takes every input word, keeps the query, accumulates distance.
    // --------------------------------------------------------------------
    lkls_front #(
        .MAX_DIMENSION (MAX_DIMENSION),
        .MAX_POINTS    (MAX_POINTS),
        .SAMPLE_BITS   (SAMPLE_BITS),
        .DIM_W         (DIM_W),
        .IDX_W         (IDX_W)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_op     (opcode_t'(s_tuser)),
        .in_sample (s_tdata[SAMPLE_BITS-1:0]),
        .dim_eff   (dim_eff),
        .keep      (keep_reg),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_kind    (push_kind),
        .q_index   (push_index),
        .q_dist    (push_dist)
    );

    // Commands keep their order, so a clear or a finish never passes an
    // insert that was queued ahead of it.
    lkls_cmd_fifo #(
        .WIDTH (CMD_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data ({push_kind, push_index, push_dist}),
        .pop       (q_pop),
        .head_data (head_data),
        .full      (q_full),
        .empty     (q_empty)
    );

    assign head_kind  = cmd_kind_t'(head_data[CMD_W-1 -: 2]);
    assign head_index = head_data[DIST_BITS +: IDX_W];
    assign head_dist  = head_data[DIST_BITS-1:0];

    // --------------------------------------------------------------------
    // Back: sorted list of the nearest points and the result stream.
    // --------------------------------------------------------------------
    lkls_back #(
        .MAX_NEIGHBORS (MAX_NEIGHBORS),
        .KW            (KW),
        .IDX_W         (IDX_W)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .k_eff     (k_eff),
        .q_empty   (q_empty),
        .q_kind    (head_kind),
        .q_index   (head_index),
        .q_dist    (head_dist),
        .q_pop     (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_index (res_index),
        .out_dist  (res_dist),
        .out_vres  (res_vres),
        .out_last  (m_tlast)
    );

    assign m_tdata = MDATA_W'({res_dist, res_index});
    assign m_tuser = res_vres;

    // --------------------------------------------------------------------
    // Assertions.
    // --------------------------------------------------------------------

    // The front only stalls when the queue cannot take its command.
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && !s_tready |-> q_full)
        else $error("input stalled while the command queue had room");

    // The front never pushes into a full queue.
    assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> !q_full)
        else $error("command pushed into a full queue");

    // The empty-list marker is always the only, and so the last, word.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser[0] |-> m_tlast)
        else $error("empty-list word without last");

    // No result word is presented right after reset.
    assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result word valid after reset");

endmodule
